@@ hw/rtl/ptts_pkg.sv @@
`default_nettype none

package ptts_pkg;

  // field widths of one task slot
  localparam int ID_W    = 8;
  localparam int IVL_W   = 16;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // most results a single dispatch may emit
  localparam int MAX_RESULTS = 16;
  localparam int SENT_W      = $clog2(MAX_RESULTS + 1);

  // command codes carried on the input tuser
  localparam logic [CMD_W-1:0] CMD_TICK         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSTALL      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_INTERVAL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_READY    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DISPATCH     = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

  // operation broadcast to every cell of the row
  typedef enum logic [3:0] {
    CELL_HOLD    = 4'd0,
    CELL_TICK    = 4'd1,
    CELL_INSTALL = 4'd2,
    CELL_DELETE  = 4'd3,
    CELL_SET_IVL = 4'd4,
    CELL_SET_RDY = 4'd5,
    CELL_SCAN    = 4'd6,
    CELL_COMPACT = 4'd7,
    CELL_ROTATE  = 4'd8
  } cell_op_t;

  // payload of one slot
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [IVL_W-1:0] ivl;
    logic [IVL_W-1:0] cd;
  } slot_t;

  // control group from the sequencer to the cells
  typedef struct packed {
    cell_op_t         op;
    logic [ID_W-1:0]  id;
    logic [IVL_W-1:0] interval;
    logic             ready_value;
    logic             phase;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/ptts_cell.sv @@
`default_nettype none

module ptts_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned NUM   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ptts_pkg::cell_ctrl_t ctrl,
  input  wire ptts_pkg::slot_t    right_slot,
  input  wire logic               right_rdy,
  input  wire logic               right_valid,
  input  wire logic               left_valid,
  input  wire logic               left_hit,
  output ptts_pkg::slot_t         slot,
  output logic                    rdy,
  output logic                    valid,
  output logic                    hit
);

  localparam logic PARITY    = 1'(INDEX % 2);
  localparam bit   IS_FIRST  = (INDEX == 0);
  localparam bit   HAS_RIGHT = (INDEX + 1 < NUM);

  logic match;
  logic install_here;
  logic pair_left;
  logic pair_right;
  logic take_right;
  logic give_left;

  // id compare and first free slot of the packed row
  assign match        = valid && (slot.id == ctrl.id);
  assign install_here = !valid && (IS_FIRST || left_valid);

  // odd-even compaction: a hole trades places with the valid slot on its right
  assign pair_left  = HAS_RIGHT && (ctrl.phase == PARITY);
  assign pair_right = !IS_FIRST && (ctrl.phase != PARITY);
  assign take_right = pair_left && !valid && right_valid;
  assign give_left  = pair_right && !left_valid && valid;

  // slot payload
  always_ff @(posedge clk) begin
    case (ctrl.op)
      ptts_pkg::CELL_TICK: begin
        if (valid && (slot.cd != '0)) begin
          if (slot.cd == ptts_pkg::IVL_W'(1)) begin
            slot.cd <= slot.ivl;
          end else begin
            slot.cd <= slot.cd - ptts_pkg::IVL_W'(1);
          end
        end
      end
      ptts_pkg::CELL_INSTALL: begin
        if (install_here) begin
          slot.id  <= ctrl.id;
          slot.ivl <= ctrl.interval;
          slot.cd  <= ctrl.interval;
        end
      end
      ptts_pkg::CELL_SET_IVL: begin
        if (match) begin
          slot.ivl <= ctrl.interval;
          slot.cd  <= ctrl.interval;
        end
      end
      ptts_pkg::CELL_COMPACT: begin
        if (take_right) begin
          slot <= right_slot;
        end
      end
      ptts_pkg::CELL_ROTATE: begin
        slot <= right_slot;
      end
      default: begin
      end
    endcase
  end

  // valid, ready and hit flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rdy   <= 1'b0;
      hit   <= 1'b0;
    end else begin
      case (ctrl.op)
        ptts_pkg::CELL_TICK: begin
          if (valid && (slot.cd == ptts_pkg::IVL_W'(1))) begin
            rdy <= 1'b1;
          end
        end
        ptts_pkg::CELL_INSTALL: begin
          if (install_here) begin
            valid <= 1'b1;
            rdy   <= 1'b0;
          end
        end
        ptts_pkg::CELL_DELETE: begin
          hit <= match;
          if (match) begin
            valid <= 1'b0;
            rdy   <= 1'b0;
          end
        end
        ptts_pkg::CELL_SET_IVL: begin
          hit <= match;
        end
        ptts_pkg::CELL_SET_RDY: begin
          hit <= match;
          if (match) begin
            rdy <= ctrl.ready_value;
          end
        end
        ptts_pkg::CELL_SCAN: begin
          hit <= left_hit;
        end
        ptts_pkg::CELL_COMPACT: begin
          hit <= left_hit;
          if (take_right) begin
            valid <= 1'b1;
            rdy   <= right_rdy;
          end else if (give_left) begin
            valid <= 1'b0;
            rdy   <= 1'b0;
          end
        end
        ptts_pkg::CELL_ROTATE: begin
          valid <= right_valid;
          rdy   <= right_rdy;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/periodic_task_tick_scheduler_core.sv @@
// Periodic task tick scheduler.
// Input channel s_*: one command per transfer; s_tuser is the command code,
// s_tdata carries task id, interval and ready value. Output channel m_*: one
// result per command, or one per dispatched task for a dispatch, m_tlast on
// the final result of a command.
// The table is a row of TASK_SLOTS cells, slot k in cell k, kept packed.
// Tick updates every cell at once and install writes the first free cell;
// unused commands leave the table as it is; each then loads its result.
// Delete, set interval and set ready flag update the cells at once and then
// shift the per-cell match flags out of the row, one cell a cycle, to learn
// whether any slot matched; delete squeezes out the holes during the same
// shift by odd-even swaps between neighbors. Dispatch rotates the whole row
// once through cell 0, one slot a cycle, and emits ready ids in slot order.
// One command at a time; s_tready high while idle.
// When the receiver stalls the result waits in the output register and a
// dispatch walk pauses until it is taken.
// Reset empties the table (all cells invalid, no ready flags).
`default_nettype none

module periodic_task_tick_scheduler_core #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // task_id [7:0], interval [23:8], ready_value [24], zero [31:25]
  input  wire logic [31:0] s_tdata,
  // command [2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // task_out [7:0], status [9:8], task_count [14:10], zero [15]
  output logic [15:0]      m_tdata,
  // dispatched [0]
  output logic [0:0]       m_tuser,
  output logic             m_tlast
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [SW-1:0] STEP_LAST = SW'(TASK_SLOTS - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(TASK_SLOTS);
  localparam logic [ptts_pkg::SENT_W-1:0] SENT_MAX =
    ptts_pkg::SENT_W'(ptts_pkg::MAX_RESULTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RESP   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_ROTATE = 5'b01000,
    S_DFIN   = 5'b10000
  } state_t;

  state_t                           state, state_next;
  logic [CW-1:0]                    count, count_next;
  logic [SW-1:0]                    step, step_next;
  logic                             found, found_next;
  logic                             scan_del, scan_del_next;
  logic [ptts_pkg::STAT_W-1:0]      status, status_next;
  logic [ptts_pkg::SENT_W-1:0]      n_sent, n_sent_next;
  logic                             pend_valid, pend_valid_next;
  logic [ptts_pkg::ID_W-1:0]        pend_id, pend_id_next;

  logic                             out_valid;
  logic [ptts_pkg::ID_W-1:0]        out_id;
  logic                             out_disp;
  logic                             out_last;
  logic [ptts_pkg::STAT_W-1:0]      out_status;
  logic [CW-1:0]                    out_count;

  logic                             out_free;
  logic                             out_load;
  logic [ptts_pkg::ID_W-1:0]        load_id;
  logic                             load_disp;
  logic                             load_last;
  logic [ptts_pkg::STAT_W-1:0]      load_status;

  ptts_pkg::cell_ctrl_t             cell_ctrl;
  ptts_pkg::slot_t                  slots [TASK_SLOTS];
  logic [TASK_SLOTS-1:0]            valid_vec;
  logic [TASK_SLOTS-1:0]            rdy_vec;
  logic [TASK_SLOTS-1:0]            hit_vec;
  logic                             hit_out;
  logic                             cur_emit;
  logic                             head_rdy_back;

  // row of cells; cell 0 wraps back into the last cell during dispatch
  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    ptts_pkg::slot_t right_slot;
    logic            right_rdy;
    logic            right_valid;
    logic            left_valid;
    logic            left_hit;

    if (g == TASK_SLOTS - 1) begin : g_wrap
      assign right_slot  = slots[0];
      assign right_rdy   = head_rdy_back;
      assign right_valid = valid_vec[0];
    end else begin : g_next
      assign right_slot  = slots[g + 1];
      assign right_rdy   = rdy_vec[g + 1];
      assign right_valid = valid_vec[g + 1];
    end

    if (g == 0) begin : g_first
      assign left_valid = 1'b0;
      assign left_hit   = 1'b0;
    end else begin : g_prev
      assign left_valid = valid_vec[g - 1];
      assign left_hit   = hit_vec[g - 1];
    end

    ptts_cell #(
      .INDEX (g),
      .NUM   (TASK_SLOTS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .right_slot  (right_slot),
      .right_rdy   (right_rdy),
      .right_valid (right_valid),
      .left_valid  (left_valid),
      .left_hit    (left_hit),
      .slot        (slots[g]),
      .rdy         (rdy_vec[g]),
      .valid       (valid_vec[g]),
      .hit         (hit_vec[g])
    );
  end

  // head of the row seen by the sequencer
  assign hit_out       = hit_vec[TASK_SLOTS-1];
  assign cur_emit      = valid_vec[0] && rdy_vec[0] && (n_sent < SENT_MAX);
  assign head_rdy_back = rdy_vec[0] && !cur_emit;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next          = state;
    count_next          = count;
    step_next           = step;
    found_next          = found;
    scan_del_next       = scan_del;
    status_next         = status;
    n_sent_next         = n_sent;
    pend_valid_next     = pend_valid;
    pend_id_next        = pend_id;
    out_load            = 1'b0;
    load_id             = '0;
    load_disp           = 1'b0;
    load_last           = 1'b1;
    load_status         = ptts_pkg::STAT_OK;
    cell_ctrl.op          = ptts_pkg::CELL_HOLD;
    cell_ctrl.id          = s_tdata[7:0];
    cell_ctrl.interval    = s_tdata[23:8];
    cell_ctrl.ready_value = s_tdata[24];
    cell_ctrl.phase       = step[0];

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          status_next = ptts_pkg::STAT_OK;
          found_next  = 1'b0;
          step_next   = '0;
          case (s_tuser)
            ptts_pkg::CMD_TICK: begin
              cell_ctrl.op = ptts_pkg::CELL_TICK;
              state_next   = S_RESP;
            end
            ptts_pkg::CMD_INSTALL: begin
              if (count == COUNT_FULL) begin
                status_next = ptts_pkg::STAT_FULL;
              end else begin
                cell_ctrl.op = ptts_pkg::CELL_INSTALL;
                count_next   = count + CW'(1);
              end
              state_next = S_RESP;
            end
            ptts_pkg::CMD_DELETE: begin
              cell_ctrl.op  = ptts_pkg::CELL_DELETE;
              scan_del_next = 1'b1;
              state_next    = S_SCAN;
            end
            ptts_pkg::CMD_SET_INTERVAL: begin
              cell_ctrl.op  = ptts_pkg::CELL_SET_IVL;
              scan_del_next = 1'b0;
              state_next    = S_SCAN;
            end
            ptts_pkg::CMD_SET_READY: begin
              cell_ctrl.op  = ptts_pkg::CELL_SET_RDY;
              scan_del_next = 1'b0;
              state_next    = S_SCAN;
            end
            ptts_pkg::CMD_DISPATCH: begin
              n_sent_next     = '0;
              pend_valid_next = 1'b0;
              state_next      = S_ROTATE;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_status = status;
          state_next  = S_IDLE;
        end
      end

      // match flags leave the row one cell a cycle; delete also compacts
      S_SCAN: begin
        cell_ctrl.op = scan_del ? ptts_pkg::CELL_COMPACT : ptts_pkg::CELL_SCAN;
        if (hit_out) begin
          found_next = 1'b1;
          if (scan_del) begin
            count_next = count - CW'(1);
          end
        end
        if (step == STEP_LAST) begin
          status_next = (found || hit_out) ? ptts_pkg::STAT_OK
                                           : ptts_pkg::STAT_NOT_FOUND;
          state_next  = S_RESP;
        end else begin
          step_next = step + SW'(1);
        end
      end

      // one slot passes cell 0 each cycle unless the output stalls; a found id
      // waits in pend until the next one shows whether it was the final result
      S_ROTATE: begin
        if (!(cur_emit && pend_valid && !out_free)) begin
          cell_ctrl.op = ptts_pkg::CELL_ROTATE;
          if (cur_emit) begin
            if (pend_valid) begin
              out_load  = 1'b1;
              load_id   = pend_id;
              load_disp = 1'b1;
              load_last = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = slots[0].id;
            n_sent_next     = n_sent + ptts_pkg::SENT_W'(1);
          end
          if (step == STEP_LAST) begin
            state_next = S_DFIN;
          end else begin
            step_next = step + SW'(1);
          end
        end
      end

      S_DFIN: begin
        if (out_free) begin
          out_load        = 1'b1;
          load_id         = pend_valid ? pend_id : '0;
          load_disp       = pend_valid;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    step     <= step_next;
    found    <= found_next;
    scan_del <= scan_del_next;
    status   <= status_next;
    n_sent   <= n_sent_next;
    pend_id  <= pend_id_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id     <= load_id;
      out_disp   <= load_disp;
      out_last   <= load_last;
      out_status <= load_status;
      out_count  <= count_next;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {1'b0, ptts_pkg::COUNT_W'(out_count), out_status, out_id};
  assign m_tuser[0] = out_disp;
  assign m_tlast    = out_last;

  // never more tasks than slots
  assert property (@(posedge clk) disable iff (rst) count <= COUNT_FULL)
    else $error("task count above table size");

  // between commands the installed count matches the occupied cells
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(valid_vec) == int'(count)))
    else $error("installed count does not match occupied cells");

  // no held dispatch result is left over once idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("dispatch result left pending");

  // a dispatch result always reports ok status
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[9:8] == ptts_pkg::STAT_OK))
    else $error("dispatch result with nonzero status");

endmodule

`default_nettype wire

@@ tb/periodic_task_tick_scheduler_core_tb.sv @@
`timescale 1ns / 100ps

module periodic_task_tick_scheduler_core_tb;

  localparam int SLOTS = 16;
  localparam int POOL_SIZE = 6;
  localparam int HOLD_AT = 120;
  localparam int HOLD_CYCLES = 300;

  // codes the block leaves unused
  localparam logic [ptts_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [ptts_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic [ptts_pkg::CMD_W-1:0] cmd;
    logic [ptts_pkg::ID_W-1:0]  id;
    logic [ptts_pkg::IVL_W-1:0] ivl;
    logic                       rv;
  } sched_cmd_t;

  typedef struct packed {
    logic [ptts_pkg::ID_W-1:0]    task_out;
    logic                         dispatched;
    logic                         last;
    logic [ptts_pkg::STAT_W-1:0]  status;
    logic [ptts_pkg::COUNT_W-1:0] count;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  periodic_task_tick_scheduler_core #(
    .TASK_SLOTS(SLOTS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #5 clk = ~clk;

  // commands waiting to be sent and results still owed by the block
  sched_cmd_t    pending_cmds[$];
  sched_result_t due_results[$];

  // shadow task table
  logic [ptts_pkg::ID_W-1:0]  tbl_id  [SLOTS];
  logic [ptts_pkg::IVL_W-1:0] tbl_ivl [SLOTS];
  logic [ptts_pkg::IVL_W-1:0] tbl_cd  [SLOTS];
  logic                       tbl_rdy [SLOTS] = '{default: 1'b0};
  int unsigned                tbl_count = 0;

  int unsigned n_accepted = 0;
  int unsigned n_taken = 0;
  int unsigned n_errors = 0;
  int unsigned n_fired = 0;
  int unsigned n_full = 0;
  int unsigned n_missing = 0;
  int unsigned total_cmds = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        hold_on = 1'b0;
  sched_cmd_t  cur_cmd;

  function automatic void add_cmd(logic [ptts_pkg::CMD_W-1:0] cmd,
                                  logic [ptts_pkg::ID_W-1:0] id,
                                  logic [ptts_pkg::IVL_W-1:0] ivl, logic rv);
    sched_cmd_t c;
    c.cmd = cmd;
    c.id  = id;
    c.ivl = ivl;
    c.rv  = rv;
    pending_cmds.push_back(c);
  endfunction

  function automatic void owe_result(logic [ptts_pkg::ID_W-1:0] tid, logic disp,
                                     logic fin, logic [ptts_pkg::STAT_W-1:0] st);
    sched_result_t r;
    r.task_out   = tid;
    r.dispatched = disp;
    r.last       = fin;
    r.status     = st;
    r.count      = tbl_count[ptts_pkg::COUNT_W-1:0];
    due_results.push_back(r);
    if (disp) n_fired++;
    if (st == ptts_pkg::STAT_FULL) n_full++;
    if (st == ptts_pkg::STAT_NOT_FOUND) n_missing++;
  endfunction

  // update the shadow table for one command and queue what it must produce
  function automatic void run_schedule(sched_cmd_t c);
    int unsigned i;
    int unsigned w;
    int unsigned n_ready;
    int unsigned k;
    logic hit;
    logic [ptts_pkg::STAT_W-1:0] st;
    hit = 1'b0;
    st  = ptts_pkg::STAT_OK;
    case (c.cmd)
      ptts_pkg::CMD_TICK: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_cd[i] != '0) begin
            tbl_cd[i] = tbl_cd[i] - ptts_pkg::IVL_W'(1);
            if (tbl_cd[i] == '0) begin
              tbl_cd[i]  = tbl_ivl[i];
              tbl_rdy[i] = 1'b1;
            end
          end
        end
      end
      ptts_pkg::CMD_INSTALL: begin
        if (tbl_count >= SLOTS) begin
          st = ptts_pkg::STAT_FULL;
        end else begin
          tbl_id[tbl_count]  = c.id;
          tbl_ivl[tbl_count] = c.ivl;
          tbl_cd[tbl_count]  = c.ivl;
          tbl_rdy[tbl_count] = 1'b0;
          tbl_count++;
        end
      end
      ptts_pkg::CMD_DELETE: begin
        // drop every match, keep the survivors in order
        w = 0;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == c.id) begin
            hit = 1'b1;
          end else begin
            tbl_id[w]  = tbl_id[i];
            tbl_ivl[w] = tbl_ivl[i];
            tbl_cd[w]  = tbl_cd[i];
            tbl_rdy[w] = tbl_rdy[i];
            w++;
          end
        end
        for (i = w; i < tbl_count; i++) tbl_rdy[i] = 1'b0;
        tbl_count = w;
        if (!hit) st = ptts_pkg::STAT_NOT_FOUND;
      end
      ptts_pkg::CMD_SET_INTERVAL: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == c.id) begin
            tbl_ivl[i] = c.ivl;
            tbl_cd[i]  = c.ivl;
            hit = 1'b1;
          end
        end
        if (!hit) st = ptts_pkg::STAT_NOT_FOUND;
      end
      ptts_pkg::CMD_SET_READY: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == c.id) begin
            tbl_rdy[i] = c.rv;
            hit = 1'b1;
          end
        end
        if (!hit) st = ptts_pkg::STAT_NOT_FOUND;
      end
      ptts_pkg::CMD_DISPATCH: begin
        n_ready = 0;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_rdy[i]) n_ready++;
        end
        if (n_ready > ptts_pkg::MAX_RESULTS) n_ready = ptts_pkg::MAX_RESULTS;
        if (n_ready == 0) owe_result('0, 1'b0, 1'b1, ptts_pkg::STAT_OK);
        k = 0;
        for (i = 0; i < tbl_count && k < n_ready; i++) begin
          if (tbl_rdy[i]) begin
            tbl_rdy[i] = 1'b0;
            k++;
            owe_result(tbl_id[i], 1'b1, k == n_ready, ptts_pkg::STAT_OK);
          end
        end
      end
      default: begin
      end
    endcase
    if (c.cmd != ptts_pkg::CMD_DISPATCH) owe_result('0, 1'b0, 1'b1, st);
  endfunction

  // sender gap: stretches of back-to-back transfers between idle stretches
  function automatic int unsigned send_gap();
    if ((n_accepted / 50) % 3 == 2) return 0;
    return $urandom_range(19);
  endfunction

  function automatic int unsigned recv_stall();
    if ((n_taken / 40) % 3 == 1) return 0;
    return $urandom_range(19);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
    end
  endtask

  // command driver
  always @(posedge clk) begin : drive_proc
    logic offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        run_schedule(cur_cmd);
        n_accepted++;
        gap_left = send_gap();
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          s_tdata <= {7'd0, cur_cmd.rv, cur_cmd.ivl, cur_cmd.id};
          s_tuser <= cur_cmd.cmd;
          offer = 1'b1;
        end
      end
      s_tvalid <= offer;
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk) begin : hold_proc
    if (rst) begin
      hold_on <= 1'b0;
    end else if (hold_on) begin
      if (hold_left > 1) begin
        hold_left--;
      end else begin
        hold_on <= 1'b0;
      end
    end else if (!hold_done && (n_taken >= HOLD_AT)) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      hold_on <= 1'b1;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : watch_proc
    sched_result_t want;
    logic take;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_taken++;
        if (due_results.size() == 0) begin
          n_errors++;
          $display("%0t: expected no result, actual id %0d status %0d count %0d",
                   $realtime, m_tdata[7:0], m_tdata[9:8], m_tdata[14:10]);
        end else begin
          want = due_results.pop_front();
          check_field("task_out", 32'(want.task_out), 32'(m_tdata[7:0]));
          check_field("status", 32'(want.status), 32'(m_tdata[9:8]));
          check_field("task_count", 32'(want.count), 32'(m_tdata[14:10]));
          check_field("dispatched", 32'(want.dispatched), 32'(m_tuser[0]));
          check_field("last", 32'(want.last), 32'(m_tlast));
        end
        stall_left = recv_stall();
      end
      if (hold_on) begin
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      m_tready <= take;
    end
  end

  initial begin : main_proc
    int unsigned n;
    int unsigned r;
    int unsigned pick;
    logic heavy;
    logic [ptts_pkg::CMD_W-1:0] cmd;
    logic [ptts_pkg::ID_W-1:0] id;
    logic [ptts_pkg::IVL_W-1:0] ivl;
    logic [ptts_pkg::ID_W-1:0] pool [POOL_SIZE];

    // empty table: tick, dispatch and the not-found cases
    add_cmd(ptts_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0);
    add_cmd(ptts_pkg::CMD_DISPATCH, 8'd0, 16'd0, 1'b0);
    add_cmd(ptts_pkg::CMD_DELETE, 8'd7, 16'd0, 1'b0);
    add_cmd(ptts_pkg::CMD_SET_INTERVAL, 8'd7, 16'd3, 1'b0);
    add_cmd(ptts_pkg::CMD_SET_READY, 8'd7, 16'd0, 1'b1);
    // zero interval never fires; extreme id and interval
    add_cmd(ptts_pkg::CMD_INSTALL, 8'd0, 16'd0, 1'b1);
    add_cmd(ptts_pkg::CMD_INSTALL, 8'hFF, 16'hFFFF, 1'b0);
    // fill the table with adjacent duplicates
    for (n = 0; n < SLOTS - 2; n++) begin
      add_cmd(ptts_pkg::CMD_INSTALL, 8'h5A, 16'd1, 1'b0);
    end
    add_cmd(ptts_pkg::CMD_INSTALL, 8'h33, 16'hFFFF, 1'b1);
    add_cmd(ptts_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0);
    add_cmd(ptts_pkg::CMD_SET_READY, 8'd0, 16'd0, 1'b1);
    add_cmd(ptts_pkg::CMD_SET_READY, 8'hFF, 16'd0, 1'b1);
    // full dispatch of every slot
    add_cmd(ptts_pkg::CMD_DISPATCH, 8'd0, 16'd0, 1'b0);
    add_cmd(ptts_pkg::CMD_SET_INTERVAL, 8'hFF, 16'd2, 1'b0);
    add_cmd(ptts_pkg::CMD_DELETE, 8'h5A, 16'd0, 1'b0);
    add_cmd(CMD_SPARE_A, 8'hFF, 16'hFFFF, 1'b1);
    add_cmd(CMD_SPARE_B, 8'h00, 16'h0000, 1'b0);

    for (n = 0; n < POOL_SIZE; n++) pool[n] = ptts_pkg::ID_W'($urandom_range(255));

    // random traffic, alternating install-heavy and balanced stretches
    for (n = 0; n < 350; n++) begin
      heavy = ((n / 50) % 2 == 0);
      r = $urandom_range(99);
      if (heavy) begin
        if (r < 40) cmd = ptts_pkg::CMD_INSTALL;
        else if (r < 62) cmd = ptts_pkg::CMD_TICK;
        else if (r < 76) cmd = ptts_pkg::CMD_DISPATCH;
        else if (r < 83) cmd = ptts_pkg::CMD_SET_INTERVAL;
        else if (r < 90) cmd = ptts_pkg::CMD_SET_READY;
        else if (r < 96) cmd = ptts_pkg::CMD_DELETE;
        else cmd = ($urandom_range(1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
      end else begin
        if (r < 18) cmd = ptts_pkg::CMD_INSTALL;
        else if (r < 48) cmd = ptts_pkg::CMD_TICK;
        else if (r < 66) cmd = ptts_pkg::CMD_DISPATCH;
        else if (r < 76) cmd = ptts_pkg::CMD_SET_INTERVAL;
        else if (r < 84) cmd = ptts_pkg::CMD_SET_READY;
        else if (r < 96) cmd = ptts_pkg::CMD_DELETE;
        else cmd = ($urandom_range(1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
      end
      // mostly ids from a small pool so commands find their tasks
      pick = $urandom_range(9);
      if (pick < 8) id = pool[$urandom_range(POOL_SIZE - 1)];
      else id = ptts_pkg::ID_W'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 70) ivl = ptts_pkg::IVL_W'($urandom_range(4));
      else if (pick < 90) ivl = ptts_pkg::IVL_W'($urandom_range(40));
      else ivl = ptts_pkg::IVL_W'($urandom_range(16'hFFFF));
      add_cmd(cmd, id, ivl, 1'($urandom_range(1)));
    end

    total_cmds = pending_cmds.size();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < total_cmds) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d commands and %0d results: %0d dispatched ids,",
             n_accepted, n_taken, n_fired);
    $display("%0d table-full installs, %0d commands naming absent tasks",
             n_full, n_missing);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog_proc
    #8_000_000;
    $display("timeout with %0d commands sent, %0d results owed",
             n_accepted, due_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
